>>> hdl/ikesa_pkg.sv
// Shared types and codes for the SA SPI table.
`default_nettype none
package ikesa_pkg;

   localparam int SPI_W    = 64;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 4;
   localparam int KIND_W   = 2;
   localparam int ACTIVE_W = 5;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

   localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DUP     = 3'd4;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  found_index;
   } result_type;

endpackage
`default_nettype wire

>>> hdl/ikesa_ifs.sv
// Request, response and register-write channel interfaces.
`default_nettype none
interface ikesa_req_if;
   logic                                valid;
   logic                                ready;
   logic [ikesa_pkg::KIND_W-1:0]        kind;
   logic                                flag_i;
   logic [ikesa_pkg::SPI_W-1:0]         initiator_spi;
   logic [ikesa_pkg::SPI_W-1:0]         responder_spi;
   logic                                original_initiator;
   logic [ikesa_pkg::INDEX_W-1:0]       entry_index;
   logic [ikesa_pkg::SPI_W-1:0]         candidate_spi;

   modport source (output valid, kind, flag_i, initiator_spi, responder_spi,
                   original_initiator, entry_index, candidate_spi, input ready);
   modport sink   (input valid, kind, flag_i, initiator_spi, responder_spi,
                   original_initiator, entry_index, candidate_spi, output ready);
endinterface

interface ikesa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ikesa_pkg::STATUS_W-1:0]      status;
   logic [ikesa_pkg::INDEX_W-1:0]       found_index;

   modport source (output valid, status, found_index, input ready);
   modport sink   (input valid, status, found_index, output ready);
endinterface

interface ikesa_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ikesa_pkg::ACTIVE_W-1:0]      active_entries;

   modport source (output valid, active_entries, input ready);
   modport sink   (input valid, active_entries, output ready);
endinterface
`default_nettype wire

>>> hdl/ike_sa_spi_table.sv
// Top level of the SA SPI table: register, sequencer, SPI memory, response stage.
//
//   channel   modport   carries
//   req_if    sink      kind, flag_i, SPIs, role, entry_index, candidate_spi
//   rsp_if    source    status, found_index
//   csr_if    sink      active_entries (always ready)
//
// Delete and zero-candidate check go straight from accept to the response state.
// Create scans the in-use marks, lookup and check scan the memory, over the active
// entries clamped to TABLE_DEPTH; lookup and check read one memory entry per cycle.
// One request is in flight; a new one is taken once the previous response
// moved to the output register, even while that response is stalled.
// Reset clears the in-use marks at once and loads 16 into active_entries.
`default_nettype none
module ike_sa_spi_table #(
   parameter int TABLE_DEPTH = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   ikesa_req_if.sink  req_if,
   ikesa_rsp_if.source rsp_if,
   ikesa_csr_if.sink  csr_if
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [ikesa_pkg::ACTIVE_W-1:0]  active_ff, active_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   ikesa_pkg::result_type           rsp_data_ff, rsp_data_in;

   ikesa_pkg::mem_ctl_type          mem_ctl;
   logic [IDX_W-1:0]                mem_addr;
   logic [ikesa_pkg::SPI_W-1:0]     mem_wdata;
   logic [ikesa_pkg::SPI_W-1:0]     mem_rdata;
   logic                            res_valid;
   logic                            out_free;
   ikesa_pkg::result_type           res;

   assign csr_if.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      active_in = active_ff;
      if (csr_if.valid) begin
         active_in = csr_if.active_entries;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ikesa_pkg::ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_data_ff.status;
   assign rsp_if.found_index = rsp_data_ff.found_index;

   ikesa_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_if.valid),
      .req_ready          (req_if.ready),
      .kind               (req_if.kind),
      .flag_i             (req_if.flag_i),
      .initiator_spi      (req_if.initiator_spi),
      .responder_spi      (req_if.responder_spi),
      .original_initiator (req_if.original_initiator),
      .entry_index        (req_if.entry_index),
      .candidate_spi      (req_if.candidate_spi),
      .active_entries     (active_ff),
      .mem_ctl            (mem_ctl),
      .mem_addr           (mem_addr),
      .mem_wdata          (mem_wdata),
      .mem_rdata          (mem_rdata),
      .res_valid          (res_valid),
      .res_take           (out_free),
      .res                (res)
   );

   ikesa_spi_mem #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_mem (
      .clock (clock),
      .ctl   (mem_ctl),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

`ifndef SYNTHESIS
   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !req_if.ready)
      else $error("request taken while a result is pending");

   a_found_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != ikesa_pkg::ST_OK) |-> rsp_if.found_index == '0)
      else $error("found_index set on a failing status");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.wr_en && mem_ctl.rd_en))
      else $error("memory read and write in the same cycle");

   a_result_moves_out: assert property (@(posedge clock) disable iff (reset)
      (res_valid && out_free) |=> rsp_if.valid)
      else $error("finished result not loaded into the response register");
`endif

endmodule
`default_nettype wire

>>> hdl/ikesa_spi_mem.sv
// Own-SPI storage: one write or read port, registered read data.
`default_nettype none
module ikesa_spi_mem #(
   parameter  int TABLE_DEPTH = 16,
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic                          clock,
   input  wire ikesa_pkg::mem_ctl_type        ctl,
   input  wire logic [AW-1:0]                 addr,
   input  wire logic [ikesa_pkg::SPI_W-1:0]   wdata,
   output logic      [ikesa_pkg::SPI_W-1:0]   rdata
);

   logic [ikesa_pkg::SPI_W-1:0] mem [TABLE_DEPTH];
   logic [ikesa_pkg::SPI_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> hdl/ikesa_ctrl.sv
// Request sequencer: in-use marks, table scan and result formation.
`default_nettype none
module ikesa_ctrl #(
   parameter  int TABLE_DEPTH = 16,
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [ikesa_pkg::KIND_W-1:0]    kind,
   input  wire logic                            flag_i,
   input  wire logic [ikesa_pkg::SPI_W-1:0]     initiator_spi,
   input  wire logic [ikesa_pkg::SPI_W-1:0]     responder_spi,
   input  wire logic                            original_initiator,
   input  wire logic [ikesa_pkg::INDEX_W-1:0]   entry_index,
   input  wire logic [ikesa_pkg::SPI_W-1:0]     candidate_spi,
   input  wire logic [ikesa_pkg::ACTIVE_W-1:0]  active_entries,
   output ikesa_pkg::mem_ctl_type               mem_ctl,
   output logic      [IDX_W-1:0]                mem_addr,
   output logic      [ikesa_pkg::SPI_W-1:0]     mem_wdata,
   input  wire logic [ikesa_pkg::SPI_W-1:0]     mem_rdata,
   output logic                                 res_valid,
   input  wire logic                            res_take,
   output ikesa_pkg::result_type                res
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > ikesa_pkg::ACTIVE_W) ? CNT_W : ikesa_pkg::ACTIVE_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [TABLE_DEPTH-1:0]          in_use_ff, in_use_in;
   logic                            pend_ff, pend_in;
   logic                            pend_ok_ff, pend_ok_in;
   logic [IDX_W-1:0]                pend_idx_ff, pend_idx_in;
   logic [ikesa_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [ikesa_pkg::SPI_W-1:0]     key_ff, key_in;
   logic [ikesa_pkg::INDEX_W-1:0]   excl_ff, excl_in;
   logic [CNT_W-1:0]                lim_ff, lim_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [ikesa_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [IDX_W-1:0]                found_ff, found_in;

   logic [CNT_W-1:0]                lim;
   logic [IDX_W-1:0]                scan_idx;
   logic                            scan_end;
   logic                            hit;
   logic                            del_in_range;

   always_comb begin
      lim = (CMP_W'(active_entries) > CMP_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(active_entries);
      scan_idx     = cnt_ff[IDX_W-1:0];
      scan_end     = (cnt_ff == lim_ff);
      hit          = pend_ff && pend_ok_ff && (mem_rdata == key_ff);
      del_in_range = CMP_W'(entry_index) < CMP_W'(TABLE_DEPTH);

      state_in    = state_ff;
      in_use_in   = in_use_ff;
      pend_in     = pend_ff;
      pend_ok_in  = pend_ok_ff;
      pend_idx_in = pend_idx_ff;
      kind_in     = kind_ff;
      key_in      = key_ff;
      excl_in     = excl_ff;
      lim_in      = lim_ff;
      cnt_in      = cnt_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      mem_ctl     = '0;
      mem_addr    = scan_idx;
      mem_wdata   = key_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = kind;
               excl_in   = entry_index;
               lim_in    = lim;
               cnt_in    = '0;
               pend_in   = 1'b0;
               found_in  = '0;
               status_in = ikesa_pkg::ST_OK;
               unique case (kind)
                  ikesa_pkg::KIND_CREATE: begin
                     // the entry keeps only its own SPI, chosen by role
                     key_in   = original_initiator ? initiator_spi : responder_spi;
                     state_in = S_SCAN;
                  end
                  ikesa_pkg::KIND_LOOKUP: begin
                     key_in   = flag_i ? responder_spi : initiator_spi;
                     state_in = S_SCAN;
                  end
                  ikesa_pkg::KIND_DELETE: begin
                     if (del_in_range) begin
                        in_use_in[IDX_W'(entry_index)] = 1'b0;
                     end
                     state_in = S_DONE;
                  end
                  ikesa_pkg::KIND_CHECK: begin
                     key_in = candidate_spi;
                     if (candidate_spi == '0) begin
                        status_in = ikesa_pkg::ST_ZERO;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (kind_ff == ikesa_pkg::KIND_CREATE) begin
               if (scan_end) begin
                  status_in = ikesa_pkg::ST_FULL;
                  state_in  = S_DONE;
               end else if (!in_use_ff[scan_idx]) begin
                  mem_ctl.wr_en       = 1'b1;
                  in_use_in[scan_idx] = 1'b1;
                  found_in            = scan_idx;
                  state_in            = S_DONE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               // read issued one entry ahead of the compare
               if (hit) begin
                  if (kind_ff == ikesa_pkg::KIND_LOOKUP) begin
                     found_in = pend_idx_ff;
                  end else begin
                     status_in = ikesa_pkg::ST_DUP;
                  end
                  state_in = S_DONE;
               end else if (scan_end && !pend_ff) begin
                  if (kind_ff == ikesa_pkg::KIND_LOOKUP) begin
                     status_in = ikesa_pkg::ST_NOMATCH;
                  end
                  state_in = S_DONE;
               end else if (!scan_end) begin
                  mem_ctl.rd_en = 1'b1;
                  pend_in       = 1'b1;
                  pend_idx_in   = scan_idx;
                  pend_ok_in    = in_use_ff[scan_idx] &&
                                  ((kind_ff != ikesa_pkg::KIND_CHECK) ||
                                   (CMP_W'(cnt_ff) != CMP_W'(excl_ff)));
                  cnt_in        = cnt_ff + 1'b1;
               end else begin
                  pend_in = 1'b0;
               end
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         in_use_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         in_use_ff <= in_use_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ok_ff  <= pend_ok_in;
      pend_idx_ff <= pend_idx_in;
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      excl_ff     <= excl_in;
      lim_ff      <= lim_in;
      cnt_ff      <= cnt_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign res_valid       = (state_ff == S_DONE);
   assign res.status      = status_ff;
   assign res.found_index = ikesa_pkg::INDEX_W'(found_ff);

endmodule
`default_nettype wire

>>> tb/sv/tb_ike_sa_spi_table.sv
// Self-checking testbench for the SA SPI table: directed, random and backpressure requests.
module tb_ike_sa_spi_table;

   localparam int TABLE_DEPTH = 16;
   localparam int STALL_LIMIT = 5000;
   localparam logic [ikesa_pkg::SPI_W-1:0] SPI_ONES = '1;
   localparam logic [ikesa_pkg::SPI_W-1:0] SPI_MSB  = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [ikesa_pkg::KIND_W-1:0]  kind;
      logic                          flag_i;
      logic [ikesa_pkg::SPI_W-1:0]   initiator_spi;
      logic [ikesa_pkg::SPI_W-1:0]   responder_spi;
      logic                          original_initiator;
      logic [ikesa_pkg::INDEX_W-1:0] entry_index;
      logic [ikesa_pkg::SPI_W-1:0]   candidate_spi;
   } table_request_type;

   logic clock = 1'b0;
   logic reset;

   ikesa_req_if req_bus ();
   ikesa_rsp_if rsp_bus ();
   ikesa_csr_if csr_bus ();

   ike_sa_spi_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the table and its register
   logic                           model_in_use [TABLE_DEPTH];
   logic                           model_role   [TABLE_DEPTH];
   logic [ikesa_pkg::SPI_W-1:0]    model_ispi   [TABLE_DEPTH];
   logic [ikesa_pkg::SPI_W-1:0]    model_rspi   [TABLE_DEPTH];
   logic [ikesa_pkg::ACTIVE_W-1:0] model_active;

   ikesa_pkg::result_type expected_answers[$];
   int error_count = 0;
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int rsp_hold_cycles = 0;
   int stall_cycles = 0;

   function automatic logic [ikesa_pkg::SPI_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [ikesa_pkg::SPI_W-1:0] own_spi_of(input int idx);
      return model_role[idx] ? model_ispi[idx] : model_rspi[idx];
   endfunction

   // Computes the answer to one request and applies its effect on the table.
   function automatic ikesa_pkg::result_type predict_answer(input table_request_type r);
      ikesa_pkg::result_type res;
      logic [ikesa_pkg::SPI_W-1:0] key;
      int lim;
      int i;
      res.status = ikesa_pkg::ST_OK;
      res.found_index = '0;
      lim = (model_active > TABLE_DEPTH) ? TABLE_DEPTH : int'(model_active);
      case (r.kind)
         ikesa_pkg::KIND_CREATE: begin
            res.status = ikesa_pkg::ST_FULL;
            for (i = 0; i < lim; i++) begin
               if (!model_in_use[i]) begin
                  model_in_use[i] = 1'b1;
                  model_role[i] = r.original_initiator;
                  model_ispi[i] = r.initiator_spi;
                  model_rspi[i] = r.responder_spi;
                  res.status = ikesa_pkg::ST_OK;
                  res.found_index = ikesa_pkg::INDEX_W'(i);
                  break;
               end
            end
         end
         ikesa_pkg::KIND_LOOKUP: begin
            key = r.flag_i ? r.responder_spi : r.initiator_spi;
            res.status = ikesa_pkg::ST_NOMATCH;
            for (i = 0; i < lim; i++) begin
               if (model_in_use[i] && own_spi_of(i) == key) begin
                  res.status = ikesa_pkg::ST_OK;
                  res.found_index = ikesa_pkg::INDEX_W'(i);
                  break;
               end
            end
         end
         ikesa_pkg::KIND_DELETE: model_in_use[r.entry_index] = 1'b0;
         default: begin
            if (r.candidate_spi == '0) begin
               res.status = ikesa_pkg::ST_ZERO;
            end else begin
               for (i = 0; i < lim; i++) begin
                  if (i != r.entry_index && model_in_use[i]
                      && own_spi_of(i) == r.candidate_spi) begin
                     res.status = ikesa_pkg::ST_DUP;
                     break;
                  end
               end
            end
         end
      endcase
      return res;
   endfunction

   function automatic int pick_used_entry();
      int used[$];
      int i;
      for (i = 0; i < TABLE_DEPTH; i++)
         if (model_in_use[i]) used.push_back(i);
      if (used.size() == 0) return -1;
      return used[$urandom_range(used.size() - 1)];
   endfunction

   function automatic table_request_type make_request(
         input logic [ikesa_pkg::KIND_W-1:0] kind,
         input logic flag, input logic [ikesa_pkg::SPI_W-1:0] ispi,
         input logic [ikesa_pkg::SPI_W-1:0] rspi,
         input logic role, input logic [ikesa_pkg::INDEX_W-1:0] idx,
         input logic [ikesa_pkg::SPI_W-1:0] cand);
      table_request_type r;
      r.kind = kind;
      r.flag_i = flag;
      r.initiator_spi = ispi;
      r.responder_spi = rspi;
      r.original_initiator = role;
      r.entry_index = idx;
      r.candidate_spi = cand;
      return r;
   endfunction

   // Mostly well-formed traffic: keys and candidates taken from live entries,
   // create/delete mix steered by occupancy so the table keeps churning.
   function automatic table_request_type random_request();
      table_request_type r;
      int occ;
      int roll;
      int pick;
      int victim;
      int i;
      occ = 0;
      for (i = 0; i < TABLE_DEPTH; i++)
         if (model_in_use[i]) occ++;
      r = make_request(ikesa_pkg::KIND_CHECK, 1'($urandom_range(1)), rand64(), rand64(),
                       1'($urandom_range(1)),
                       ikesa_pkg::INDEX_W'($urandom_range(TABLE_DEPTH - 1)), rand64());
      roll = $urandom_range(99);
      if (roll < 40 - 2 * occ) r.kind = ikesa_pkg::KIND_CREATE;
      else if (roll < 48) r.kind = ikesa_pkg::KIND_DELETE;
      else if (roll < 78) r.kind = ikesa_pkg::KIND_LOOKUP;
      victim = pick_used_entry();
      pick = $urandom_range(19);
      case (r.kind)
         ikesa_pkg::KIND_CREATE: begin
            if (pick < 3 && victim >= 0) begin
               r.initiator_spi = own_spi_of(victim);
               r.responder_spi = own_spi_of(victim);
            end else if (pick < 5) begin
               r.initiator_spi = ikesa_pkg::SPI_W'($urandom_range(3));
               r.responder_spi = ikesa_pkg::SPI_W'($urandom_range(3));
            end else if (pick == 5) begin
               r.initiator_spi = SPI_ONES;
               r.responder_spi = SPI_MSB;
            end else if (pick == 6) begin
               r.initiator_spi = '0;
            end
         end
         ikesa_pkg::KIND_LOOKUP: begin
            if (pick < 14 && victim >= 0) begin
               if (r.flag_i) r.responder_spi = own_spi_of(victim);
               else r.initiator_spi = own_spi_of(victim);
            end else if (pick < 16) begin
               r.initiator_spi = ikesa_pkg::SPI_W'($urandom_range(3));
               r.responder_spi = ikesa_pkg::SPI_W'($urandom_range(3));
            end
         end
         ikesa_pkg::KIND_DELETE: begin
            if (pick < 15 && victim >= 0) r.entry_index = ikesa_pkg::INDEX_W'(victim);
         end
         default: begin
            if (pick < 2) begin
               r.candidate_spi = '0;
            end else if (pick < 10 && victim >= 0) begin
               r.candidate_spi = own_spi_of(victim);
               if (pick < 6) r.entry_index = ikesa_pkg::INDEX_W'(victim);
            end else if (pick < 12) begin
               r.candidate_spi = ikesa_pkg::SPI_W'($urandom_range(3));
            end
         end
      endcase
      return r;
   endfunction

   // Leaves valid high on return; the caller lowers it when the stream pauses.
   task automatic send_request(input table_request_type r);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind <= r.kind;
      req_bus.flag_i <= r.flag_i;
      req_bus.initiator_spi <= r.initiator_spi;
      req_bus.responder_spi <= r.responder_spi;
      req_bus.original_initiator <= r.original_initiator;
      req_bus.entry_index <= r.entry_index;
      req_bus.candidate_spi <= r.candidate_spi;
      do @(posedge clock); while (!req_bus.ready);
      expected_answers.push_back(predict_answer(r));
   endtask

   task automatic drain_answers();
      req_bus.valid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_active_entries(input logic [ikesa_pkg::ACTIVE_W-1:0] value);
      drain_answers();
      csr_bus.valid <= 1'b1;
      csr_bus.active_entries <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      model_active = value;
   endtask

   task automatic test_directed_ops();
      send_request(make_request(ikesa_pkg::KIND_CHECK, 1'b0, '0, '0, 1'b0, 4'd0, '0));
      send_request(make_request(ikesa_pkg::KIND_CHECK, 1'b1, SPI_ONES, SPI_ONES, 1'b1,
                                4'd15, SPI_ONES));
      send_request(make_request(ikesa_pkg::KIND_LOOKUP, 1'b0, SPI_ONES, '0, 1'b0,
                                4'd0, SPI_ONES));
      send_request(make_request(ikesa_pkg::KIND_CREATE, 1'b0, SPI_ONES, '0, 1'b1,
                                4'd15, '0));
      // entry 1 owns the same SPI through its responder word
      send_request(make_request(ikesa_pkg::KIND_CREATE, 1'b1, 64'd1, SPI_ONES, 1'b0,
                                4'd0, SPI_ONES));
      send_request(make_request(ikesa_pkg::KIND_LOOKUP, 1'b0, SPI_ONES, '0, 1'b1,
                                4'd15, '0));
      send_request(make_request(ikesa_pkg::KIND_LOOKUP, 1'b1, '0, SPI_ONES, 1'b0,
                                4'd0, '0));
      send_request(make_request(ikesa_pkg::KIND_CHECK, 1'b0, '0, '0, 1'b0, 4'd0, SPI_ONES));
      send_request(make_request(ikesa_pkg::KIND_DELETE, 1'b0, '0, '0, 1'b0, 4'd1, '0));
      send_request(make_request(ikesa_pkg::KIND_CHECK, 1'b0, '0, '0, 1'b0, 4'd0, SPI_ONES));
      send_request(make_request(ikesa_pkg::KIND_DELETE, 1'b1, SPI_ONES, SPI_ONES, 1'b1,
                                4'd1, SPI_ONES));
      send_request(make_request(ikesa_pkg::KIND_CREATE, 1'b0, SPI_MSB, SPI_MSB, 1'b0,
                                4'd7, SPI_MSB));
      send_request(make_request(ikesa_pkg::KIND_LOOKUP, 1'b1, '0, SPI_MSB, 1'b0, 4'd0, '0));
      send_request(make_request(ikesa_pkg::KIND_LOOKUP, 1'b0, SPI_MSB, '0, 1'b0, 4'd0, '0));
      send_request(make_request(ikesa_pkg::KIND_DELETE, 1'b0, '0, '0, 1'b0, 4'd15, '0));
      drain_answers();
   endtask

   task automatic test_scan_limits();
      write_active_entries(5'd0);
      send_request(make_request(ikesa_pkg::KIND_CREATE, 1'b0, 64'h55, 64'haa, 1'b1,
                                4'd0, '0));
      send_request(make_request(ikesa_pkg::KIND_LOOKUP, 1'b0, SPI_ONES, '0, 1'b0,
                                4'd0, '0));
      send_request(make_request(ikesa_pkg::KIND_CHECK, 1'b0, '0, '0, 1'b0, 4'd15, SPI_ONES));
      send_request(make_request(ikesa_pkg::KIND_CHECK, 1'b0, '0, '0, 1'b0, 4'd15, '0));
      send_request(make_request(ikesa_pkg::KIND_DELETE, 1'b0, '0, '0, 1'b0, 4'd15, '0));
      write_active_entries(5'd2);
      send_request(make_request(ikesa_pkg::KIND_CREATE, 1'b0, 64'h55, 64'haa, 1'b1,
                                4'd0, '0));
      write_active_entries(5'd31);
      send_request(make_request(ikesa_pkg::KIND_CREATE, 1'b0, 64'h1234, 64'h5678, 1'b1,
                                4'd0, '0));
      send_request(make_request(ikesa_pkg::KIND_LOOKUP, 1'b1, '0, 64'h9999, 1'b0,
                                4'd0, '0));
      // entry 1 lies beyond the scan window but can still be freed
      write_active_entries(5'd1);
      send_request(make_request(ikesa_pkg::KIND_LOOKUP, 1'b1, '0, SPI_MSB, 1'b0, 4'd0, '0));
      send_request(make_request(ikesa_pkg::KIND_DELETE, 1'b0, '0, '0, 1'b0, 4'd1, '0));
      write_active_entries(5'd16);
      send_request(make_request(ikesa_pkg::KIND_CREATE, 1'b1, 64'h77, 64'h88, 1'b0,
                                4'd3, '0));
      drain_answers();
   endtask

   task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct);
      int chunk;
      int n;
      int pick;
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      for (chunk = 0; chunk < 3; chunk++) begin
         pick = $urandom_range(19);
         if (pick == 0) write_active_entries(5'd0);
         else if (pick < 3) write_active_entries(5'd1);
         else if (pick < 6)
            write_active_entries(ikesa_pkg::ACTIVE_W'($urandom_range(15, 2)));
         else if (pick < 8)
            write_active_entries(ikesa_pkg::ACTIVE_W'($urandom_range(31, 17)));
         else write_active_entries(5'd16);
         for (n = 0; n < count / 3; n++) send_request(random_request());
      end
      drain_answers();
   endtask

   // Response side stops for a long stretch while requests keep coming.
   task automatic test_backpressure();
      int n;
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      write_active_entries(5'd16);
      @(posedge clock);
      rsp_hold_cycles = 300;
      for (n = 0; n < 40; n++) send_request(random_request());
      drain_answers();
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      ikesa_pkg::result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: response with nothing pending: status=%0d index=%0d",
                     $time, rsp_bus.status, rsp_bus.found_index);
            error_count++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.found_index !== want.found_index) begin
               $display("%0t: found_index expected %0d actual %0d",
                        $time, want.found_index, rsp_bus.found_index);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      int i;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.kind <= ikesa_pkg::KIND_CREATE;
      req_bus.flag_i <= 1'b0;
      req_bus.initiator_spi <= '0;
      req_bus.responder_spi <= '0;
      req_bus.original_initiator <= 1'b0;
      req_bus.entry_index <= '0;
      req_bus.candidate_spi <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.active_entries <= ikesa_pkg::ACTIVE_RESET;
      model_active = ikesa_pkg::ACTIVE_RESET;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         model_in_use[i] = 1'b0;
         model_role[i] = 1'b0;
         model_ispi[i] = '0;
         model_rspi[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_ops();
      test_scan_limits();
      test_random_traffic(460, 10, 45);
      test_random_traffic(460, 45, 10);
      test_backpressure();
      test_random_traffic(460, 0, 0);

      drain_answers();
      repeat (25) @(posedge clock);
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

>>> files.f
hdl/ikesa_pkg.sv
hdl/ikesa_ifs.sv
hdl/ikesa_spi_mem.sv
hdl/ikesa_ctrl.sv
hdl/ike_sa_spi_table.sv
tb/sv/tb_ike_sa_spi_table.sv
